// File: sv/cqwi_pkg.sv
package cqwi_pkg;

    localparam int CAP_W   = 9;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 2;
    localparam int CMD_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_RUN    = 3'd1;
    localparam logic [2:0] KIND_STOP   = 3'd2;
    localparam logic [2:0] KIND_CLEAR  = 3'd3;
    localparam logic [2:0] KIND_EVENT  = 3'd4;
    localparam logic [2:0] KIND_STATUS = 3'd5;

    localparam logic [2:0] EVT_SKIP_A = 3'd1;
    localparam logic [2:0] EVT_SKIP_B = 3'd2;
    localparam logic [2:0] EVT_SKIP_C = 3'd3;

    typedef enum logic [1:0] {
        OUT_ISSUE    = 2'd0,
        OUT_FINISHED = 2'd1,
        OUT_ERROR    = 2'd2,
        OUT_STATUS   = 2'd3
    } t_out_kind;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_FULL          = 2'd1,
        ERR_CLEAR_RUNNING = 2'd2
    } t_err_code;

    typedef struct packed {
        logic      do_write;
        logic      has_single;
        t_out_kind kind;
        t_err_code err;
        logic      running;
        logic      active;
    } t_job_ctl;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_ISSUE,
        BK_SINGLE
    } t_back_state;

endpackage

// File: sv/cqwi_if.sv
interface cqwi_cmd_if import cqwi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [CMD_W-1:0] entry_word;
    logic [2:0]       event_code;

    modport source(output valid, kind, entry_word, event_code, input ready);
    modport sink(input valid, kind, entry_word, event_code, output ready);
endinterface

interface cqwi_res_if import cqwi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       out_kind;
    logic [CMD_W-1:0] command_word;
    logic             last_of_run;
    logic [1:0]       error_code;
    logic             is_running;
    logic             is_active;

    modport source(output valid, out_kind, command_word, last_of_run, error_code,
                   is_running, is_active, input ready);
    modport sink(input valid, out_kind, command_word, last_of_run, error_code,
                 is_running, is_active, output ready);
endinterface

// File: sv/cqwi_front.sv
module cqwi_front import cqwi_pkg::*; #(
    parameter int QUEUE_DEPTH   = 256,
    parameter int MAX_IN_FLIGHT = 3,
    parameter int ENTRY_BITS    = 32,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int NUM_W = $clog2(MAX_IN_FLIGHT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cqwi_cmd_if.sink              i_cmd,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job_ctl              o_job_ctl,
    output logic [IDX_W-1:0]      o_job_waddr,
    output logic [ENTRY_BITS-1:0] o_job_wdata,
    output logic [IDX_W-1:0]      o_job_start,
    output logic [NUM_W-1:0]      o_job_num
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic [CNT_W-1:0] r_complete, n_complete;
    logic             r_active, n_active;
    logic             r_running, n_running;
    logic             r_stop, n_stop;
    logic [CAP_W-1:0] r_cap;

    logic             w_accept;
    logic             w_full;
    logic             w_skip_evt;
    logic             w_clear;
    logic             w_burst;
    logic             w_write;
    logic             w_single;
    t_out_kind        w_kind;
    t_err_code        w_err;
    logic [NUM_W-1:0] w_num;

    assign pready      = 1'b1;
    assign prdata      = APB_W'(r_cap);
    assign i_cmd.ready = i_job_ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_full = (32'(r_count) >= 32'(r_cap)) || (32'(r_count) >= 32'(QUEUE_DEPTH));
    assign w_skip_evt = (i_cmd.event_code == EVT_SKIP_A) || (i_cmd.event_code == EVT_SKIP_B)
                     || (i_cmd.event_code == EVT_SKIP_C);

    always_comb begin
        n_count    = r_count;
        n_complete = r_complete;
        n_active   = r_active;
        n_running  = r_running;
        n_stop     = r_stop;
        w_clear    = 1'b0;
        w_burst    = 1'b0;
        w_write    = 1'b0;
        w_single   = 1'b0;
        w_kind     = OUT_ISSUE;
        w_err      = ERR_NONE;
        unique case (i_cmd.kind)
            KIND_ADD: begin
                if (w_full) begin
                    w_single = 1'b1;
                    w_kind   = OUT_ERROR;
                    w_err    = ERR_FULL;
                end else begin
                    w_write = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_active && !r_running) begin
                        n_running = 1'b1;
                        w_burst   = 1'b1;
                    end
                end
            end
            KIND_RUN: begin
                if (!r_running) begin
                    n_active = 1'b1;
                    if (r_complete < r_count) begin
                        n_running = 1'b1;
                        w_burst   = 1'b1;
                    end
                end
            end
            KIND_STOP: begin
                if (r_active) begin
                    if (!r_running) begin
                        n_active = 1'b0;
                    end else begin
                        n_stop = 1'b1;
                    end
                end
            end
            KIND_CLEAR: begin
                if (r_active && r_running) begin
                    w_single = 1'b1;
                    w_kind   = OUT_ERROR;
                    w_err    = ERR_CLEAR_RUNNING;
                end else begin
                    w_clear    = 1'b1;
                    n_count    = '0;
                    n_complete = '0;
                end
            end
            KIND_EVENT: begin
                if (r_running && !w_skip_evt) begin
                    n_complete = r_complete + 1'b1;
                    if (r_stop) begin
                        n_active  = 1'b0;
                        n_running = 1'b0;
                        n_stop    = 1'b0;
                    end else if (n_complete < r_count) begin
                        w_burst = 1'b1;
                    end else begin
                        n_running = 1'b0;
                        w_single  = 1'b1;
                        w_kind    = OUT_FINISHED;
                    end
                end
            end
            KIND_STATUS: begin
                w_single = 1'b1;
                w_kind   = OUT_STATUS;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_num = '0;
        for (int k = 0; k < MAX_IN_FLIGHT; k++) begin
            if (w_burst && !n_stop
                && (32'(r_issue) + 32'(k) < 32'(n_count))
                && (32'(r_issue) + 32'(k) < 32'(n_complete) + 32'(MAX_IN_FLIGHT))) begin
                w_num = NUM_W'(k + 1);
            end
        end
        n_issue = w_clear ? '0 : r_issue + CNT_W'(w_num);
    end

    assign o_job_valid         = w_accept && (w_write || w_single || (w_num != '0));
    assign o_job_ctl.do_write   = w_write;
    assign o_job_ctl.has_single = w_single;
    assign o_job_ctl.kind       = w_kind;
    assign o_job_ctl.err        = w_err;
    assign o_job_ctl.running    = n_running;
    assign o_job_ctl.active     = n_active;
    assign o_job_waddr          = r_count[IDX_W-1:0];
    assign o_job_wdata          = ENTRY_BITS'(i_cmd.entry_word);
    assign o_job_start          = r_issue[IDX_W-1:0];
    assign o_job_num            = w_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_issue    <= '0;
            r_complete <= '0;
            r_active   <= 1'b0;
            r_running  <= 1'b0;
            r_stop     <= 1'b0;
            r_cap      <= CAP_RESET;
        end else begin
            if (w_accept) begin
                r_count    <= n_count;
                r_issue    <= n_issue;
                r_complete <= n_complete;
                r_active   <= n_active;
                r_running  <= n_running;
                r_stop     <= n_stop;
            end
            if (psel && penable && pwrite && pready) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
    end

endmodule

// File: sv/cqwi_fifo.sv
module cqwi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_fill;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_fill != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: sv/cqwi_back.sv
module cqwi_back import cqwi_pkg::*; #(
    parameter int QUEUE_DEPTH   = 256,
    parameter int MAX_IN_FLIGHT = 3,
    parameter int ENTRY_BITS    = 32,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int NUM_W = $clog2(MAX_IN_FLIGHT + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  t_job_ctl              i_job_ctl,
    input  logic [IDX_W-1:0]      i_job_waddr,
    input  logic [ENTRY_BITS-1:0] i_job_wdata,
    input  logic [IDX_W-1:0]      i_job_start,
    input  logic [NUM_W-1:0]      i_job_num,
    cqwi_res_if.source            o_res
);

    logic [ENTRY_BITS-1:0] r_mem [QUEUE_DEPTH];
    t_back_state           r_state, n_state;
    t_job_ctl              r_ctl;
    logic [IDX_W-1:0]      r_addr;
    logic [NUM_W-1:0]      r_left;
    logic [ENTRY_BITS-1:0] r_rdata;
    logic [63:0]           w_word;
    logic                  w_take;

    assign w_word = 64'(r_rdata);
    assign w_take = (r_state == BK_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    if (i_job_num != '0) begin
                        n_state = BK_READ;
                    end else if (i_job_ctl.has_single) begin
                        n_state = BK_SINGLE;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_ISSUE;
            end
            BK_ISSUE: begin
                if (o_res.ready) begin
                    n_state = (r_left == NUM_W'(1)) ? BK_IDLE : BK_READ;
                end
            end
            BK_SINGLE: begin
                if (o_res.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready        = (r_state == BK_IDLE);
        o_res.valid        = (r_state == BK_ISSUE) || (r_state == BK_SINGLE);
        o_res.out_kind     = r_ctl.kind;
        o_res.error_code   = r_ctl.err;
        o_res.is_running   = r_ctl.running;
        o_res.is_active    = r_ctl.active;
        o_res.command_word = (r_state == BK_ISSUE) ? w_word[CMD_W-1:0] : '0;
        o_res.last_of_run  = (r_state == BK_SINGLE) || (r_left == NUM_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ctl  <= i_job_ctl;
            r_addr <= i_job_start;
            r_left <= i_job_num;
            if (i_job_ctl.do_write) begin
                r_mem[i_job_waddr] <= i_job_wdata;
            end
        end
        if (r_state == BK_READ) begin
            r_rdata <= r_mem[r_addr];
        end
        if ((r_state == BK_ISSUE) && o_res.ready) begin
            r_addr <= r_addr + 1'b1;
            r_left <= r_left - 1'b1;
        end
    end

endmodule

// File: sv/command_queue_window_issuer.sv
// Command queue with an issue window.
// Requests arrive on i_cmd (valid/ready): add, run, stop, clear, completion
// event and status query. Results leave on o_res (valid/ready), one request
// giving zero to MAX_IN_FLIGHT results, the last one flagged by last_of_run.
// The APB port holds queue_capacity at address 0; write it only while idle.
// The front stage takes a request, updates the counters and flags, and
// posts a job to a two-entry job queue. The back stage writes the
// descriptor store and emits results: an issued command takes a store read,
// then the output register; any other result goes to the output directly.
// A request is taken while the job queue has room, so the front keeps going
// while the back waits on o_res.ready. The back takes a new job only when
// idle, once the last result of the previous job has been taken.
// Synchronous reset empties the queue, detaches it and restores the capacity
// to 256; the store contents are not cleared.
module command_queue_window_issuer import cqwi_pkg::*; #(
    parameter int QUEUE_DEPTH   = 256,
    parameter int MAX_IN_FLIGHT = 3,
    parameter int ENTRY_BITS    = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cqwi_cmd_if.sink           i_cmd,
    cqwi_res_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int NUM_W = $clog2(MAX_IN_FLIGHT + 1);
    localparam int CTL_W = $bits(t_job_ctl);
    localparam int JOB_W = CTL_W + IDX_W + ENTRY_BITS + IDX_W + NUM_W;

    logic                  f_valid, f_ready;
    t_job_ctl              f_ctl;
    logic [IDX_W-1:0]      f_waddr, f_start;
    logic [ENTRY_BITS-1:0] f_wdata;
    logic [NUM_W-1:0]      f_num;

    logic                  b_valid, b_ready;
    t_job_ctl              b_ctl;
    logic [IDX_W-1:0]      b_waddr, b_start;
    logic [ENTRY_BITS-1:0] b_wdata;
    logic [NUM_W-1:0]      b_num;

    logic [JOB_W-1:0]      w_push_data, w_pop_data;

    cqwi_front #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_IN_FLIGHT(MAX_IN_FLIGHT),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_job_valid(f_valid),
        .i_job_ready(f_ready),
        .o_job_ctl  (f_ctl),
        .o_job_waddr(f_waddr),
        .o_job_wdata(f_wdata),
        .o_job_start(f_start),
        .o_job_num  (f_num)
    );

    assign w_push_data = {f_ctl, f_waddr, f_wdata, f_start, f_num};

    cqwi_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(f_valid),
        .o_push_ready(f_ready),
        .i_push_data (w_push_data),
        .o_pop_valid (b_valid),
        .i_pop_ready (b_ready),
        .o_pop_data  (w_pop_data)
    );

    assign {b_ctl, b_waddr, b_wdata, b_start, b_num} = w_pop_data;

    cqwi_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_IN_FLIGHT(MAX_IN_FLIGHT),
        .ENTRY_BITS   (ENTRY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(b_valid),
        .o_job_ready(b_ready),
        .i_job_ctl  (b_ctl),
        .i_job_waddr(b_waddr),
        .i_job_wdata(b_wdata),
        .i_job_start(b_start),
        .i_job_num  (b_num),
        .o_res      (o_res)
    );

endmodule

// File: sv/cqwi_checker.sv
module cqwi_checker import cqwi_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [1:0]       i_out_kind,
    input logic [CMD_W-1:0] i_command_word,
    input logic             i_last_of_run,
    input logic [1:0]       i_error_code,
    input logic             i_is_running,
    input logic             i_is_active
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_command_word) && $stable(i_out_kind))
        else $error("result dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result shown right after reset");

    a_issue_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_out_kind == OUT_ISSUE) |-> i_is_running && i_is_active
                                                && (i_error_code == ERR_NONE))
        else $error("command issued on an idle or detached queue");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_out_kind == OUT_FINISHED) |-> !i_is_running && i_last_of_run
                                                   && (i_command_word == '0))
        else $error("finished result while still running");

    a_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_out_kind == OUT_ERROR) |-> (i_error_code != ERR_NONE) && i_last_of_run)
        else $error("error result without a code");

endmodule

bind command_queue_window_issuer cqwi_checker u_cqwi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_out_kind    (o_res.out_kind),
    .i_command_word(o_res.command_word),
    .i_last_of_run (o_res.last_of_run),
    .i_error_code  (o_res.error_code),
    .i_is_running  (o_res.is_running),
    .i_is_active   (o_res.is_active)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cqwi_pkg::*;

    localparam int          CLK_PERIOD    = 10;
    localparam int          QUEUE_DEPTH   = 256;
    localparam int          WINDOW        = 3;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          LIMIT_CYCLES  = 200000;
    localparam int unsigned PHASE_ITEMS   = 101;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam logic [2:0] EVT_DONE_A = 3'd0;
    localparam logic [2:0] EVT_DONE_B = 3'd4;
    localparam logic [2:0] EVT_DONE_C = 3'd5;
    localparam logic [2:0] EVT_DONE_D = 3'd6;
    localparam logic [2:0] DONE_CODES [4] = '{EVT_DONE_A, EVT_DONE_B, EVT_DONE_C, EVT_DONE_D};

    localparam logic [PADDR_W-1:0] ADDR_QUEUE_CAPACITY = '0;

    typedef struct packed {
        t_out_kind        kind;
        logic [CMD_W-1:0] word;
        logic             last;
        t_err_code        err;
        logic             running;
        logic             active;
    } t_queue_result;

    typedef struct packed {
        logic [2:0]       kind;
        logic [CMD_W-1:0] word;
        logic [2:0]       code;
        logic             typed;
        t_queue_result    want;
    } t_stim_row;

    localparam t_queue_result NO_CHECK = '0;

    localparam int N_DIRECTED = 26;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{KIND_STATUS, 32'h0, EVT_DONE_A, 1'b1,
          '{OUT_STATUS, 32'h0, 1'b1, ERR_NONE, 1'b0, 1'b0}},
        '{KIND_SPARE_A, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_SPARE_B, 32'hFFFF_FFFF, EVT_DONE_D, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_STOP, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_CLEAR, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_RUN, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_STATUS, 32'h0, EVT_DONE_A, 1'b1,
          '{OUT_STATUS, 32'h0, 1'b1, ERR_NONE, 1'b0, 1'b1}},
        '{KIND_STOP, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_ADD, 32'h0000_0000, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_ADD, 32'hFFFF_FFFF, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_ADD, 32'h0000_1234, EVT_DONE_A, 1'b1,
          '{OUT_ERROR, 32'h0, 1'b1, ERR_FULL, 1'b0, 1'b0}},
        '{KIND_RUN, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_RUN, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_CLEAR, 32'h0, EVT_DONE_A, 1'b1,
          '{OUT_ERROR, 32'h0, 1'b1, ERR_CLEAR_RUNNING, 1'b1, 1'b1}},
        '{KIND_EVENT, 32'h0, EVT_SKIP_A, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_SKIP_B, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_SKIP_C, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_DONE_D, 1'b0, NO_CHECK},
        '{KIND_STATUS, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_CLEAR, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_ADD, 32'hA5A5_A5A5, EVT_DONE_C, 1'b0, NO_CHECK},
        '{KIND_STOP, 32'h0, EVT_DONE_A, 1'b0, NO_CHECK},
        '{KIND_EVENT, 32'h0, EVT_DONE_B, 1'b0, NO_CHECK},
        '{KIND_STATUS, 32'h0, EVT_DONE_A, 1'b1,
          '{OUT_STATUS, 32'h0, 1'b1, ERR_NONE, 1'b0, 1'b0}}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_W-1:0]   pwdata;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    cqwi_cmd_if cmd_bus ();
    cqwi_res_if res_bus ();

    command_queue_window_issuer #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .MAX_IN_FLIGHT(WINDOW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_res  (res_bus),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic [CMD_W-1:0] desc_store [QUEUE_DEPTH];
    int unsigned      desc_count;
    int unsigned      issued_count;
    int unsigned      done_count;
    int unsigned      capacity_limit;
    bit               attached;
    bit               busy;
    bit               stop_held;

    t_queue_result    step_results [WINDOW+1];
    int               step_count;
    t_queue_result    results_due [$];

    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    bit               calm;
    int               mismatches;
    int               cycle_count;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    function automatic bit is_skipped_code(logic [2:0] code);
        return code == EVT_SKIP_A || code == EVT_SKIP_B || code == EVT_SKIP_C;
    endfunction

    function automatic void note_result(t_out_kind kind, logic [CMD_W-1:0] word,
                                        t_err_code err);
        step_results[step_count] = '{kind, word, 1'b0, err, 1'b0, 1'b0};
        step_count++;
    endfunction

    function automatic void fill_window();
        int sent;
        sent = 0;
        if (stop_held) return;
        while (sent < WINDOW && issued_count < desc_count &&
               issued_count < done_count + WINDOW) begin
            note_result(OUT_ISSUE, desc_store[issued_count], ERR_NONE);
            issued_count++;
            sent++;
        end
    endfunction

    function automatic void predict_queue_step(logic [2:0] kind, logic [CMD_W-1:0] word,
                                               logic [2:0] code);
        int unsigned bound;
        bound = capacity_limit < QUEUE_DEPTH ? capacity_limit : QUEUE_DEPTH;
        step_count = 0;
        case (kind)
            KIND_ADD: begin
                if (desc_count >= bound) begin
                    note_result(OUT_ERROR, '0, ERR_FULL);
                end else begin
                    desc_store[desc_count] = word;
                    desc_count++;
                    if (attached && !busy) begin
                        busy = 1'b1;
                        fill_window();
                    end
                end
            end
            KIND_RUN: begin
                if (!busy) begin
                    attached = 1'b1;
                    if (done_count < desc_count) begin
                        busy = 1'b1;
                        fill_window();
                    end
                end
            end
            KIND_STOP: begin
                if (attached) begin
                    if (!busy) attached = 1'b0;
                    else stop_held = 1'b1;
                end
            end
            KIND_CLEAR: begin
                if (attached && busy) begin
                    note_result(OUT_ERROR, '0, ERR_CLEAR_RUNNING);
                end else begin
                    desc_count   = 0;
                    issued_count = 0;
                    done_count   = 0;
                end
            end
            KIND_EVENT: begin
                if (busy && !is_skipped_code(code)) begin
                    done_count++;
                    if (stop_held) begin
                        attached  = 1'b0;
                        busy      = 1'b0;
                        stop_held = 1'b0;
                    end else if (done_count < desc_count) begin
                        fill_window();
                    end else begin
                        busy = 1'b0;
                        note_result(OUT_FINISHED, '0, ERR_NONE);
                    end
                end
            end
            KIND_STATUS: begin
                note_result(OUT_STATUS, '0, ERR_NONE);
            end
            default: begin
            end
        endcase
        for (int k = 0; k < step_count; k++) begin
            step_results[k].last    = (k == step_count - 1);
            step_results[k].running = busy;
            step_results[k].active  = attached;
        end
    endfunction

    function automatic void check_field(string name, logic [APB_W-1:0] want,
                                        logic [APB_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic apb_transfer(input bit wr, input logic [APB_W-1:0] wdata,
                                output logic [APB_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_QUEUE_CAPACITY;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(input int unsigned value);
        logic [APB_W-1:0] readback;
        apb_transfer(1'b1, value, readback);
        capacity_limit = value;
        apb_transfer(1'b0, '0, readback);
        check_field("queue_capacity", value, readback);
    endtask

    task automatic wait_drained();
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [2:0] kind, input logic [CMD_W-1:0] word,
                                input logic [2:0] code, input bit hold,
                                input bit typed, input t_queue_result want);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < send_idle_pct) gap++;
        end
        if (gap > 0 || hold) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (hold) begin
                do @(posedge i_clk); while (results_due.size() != 0);
            end
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.kind       <= kind;
        cmd_bus.entry_word <= word;
        cmd_bus.event_code <= code;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predict_queue_step(kind, word, code);
        if (typed) begin
            results_due.push_back(want);
        end else begin
            for (int k = 0; k < step_count; k++) results_due.push_back(step_results[k]);
        end
    endtask

    task automatic run_random_phase(input int unsigned quota);
        int unsigned sent_no;
        int unsigned pick;
        logic [2:0]  kind;
        logic [2:0]  code;
        sent_no = 0;
        while (sent_no < quota) begin
            pick = $urandom_range(99);
            if ($urandom_range(4) == 0) code = $urandom_range(EVT_SKIP_C, EVT_SKIP_A);
            else code = DONE_CODES[$urandom_range(3)];
            if (pick < 30) kind = KIND_ADD;
            else if (pick < 62) kind = KIND_EVENT;
            else if (pick < 70) kind = KIND_RUN;
            else if (pick < 75) kind = KIND_STOP;
            else if (pick < 80) kind = KIND_CLEAR;
            else if (pick < 95) kind = KIND_STATUS;
            else kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
            calm = ((sent_no / 20) % 4 == 3);
            send_request(kind, $urandom(), code, sent_no == quota / 2, 1'b0, NO_CHECK);
            sent_no++;
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        res_bus.ready <= calm || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result expected none actual kind %0h word %0h", $time,
                         res_bus.out_kind, res_bus.command_word);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                check_field("out_kind", want.kind, res_bus.out_kind);
                check_field("command_word", want.word, res_bus.command_word);
                check_field("last_of_run", want.last, res_bus.last_of_run);
                check_field("error_code", want.err, res_bus.error_code);
                check_field("is_running", want.running, res_bus.is_running);
                check_field("is_active", want.active, res_bus.is_active);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [APB_W-1:0] reset_value;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.kind       = KIND_STATUS;
        cmd_bus.entry_word = '0;
        cmd_bus.event_code = EVT_DONE_A;
        res_bus.ready      = 1'b0;
        desc_count         = 0;
        issued_count       = 0;
        done_count         = 0;
        capacity_limit     = CAP_RESET;
        attached           = 1'b0;
        busy               = 1'b0;
        stop_held          = 1'b0;
        calm               = 1'b0;
        mismatches         = 0;
        cycle_count        = 0;
        send_idle_pct      = 38;
        recv_idle_pct      = 70;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_transfer(1'b0, '0, reset_value);
        check_field("queue_capacity", CAP_RESET, reset_value);
        set_capacity(2);
        for (int r = 0; r < N_DIRECTED; r++) begin
            send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].code,
                         1'b0, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        cmd_bus.valid <= 1'b0;
        wait_drained();

        set_capacity(QUEUE_DEPTH);
        run_random_phase(PHASE_ITEMS);
        cmd_bus.valid <= 1'b0;
        wait_drained();

        send_idle_pct = 70;
        recv_idle_pct = 38;
        set_capacity(1);
        run_random_phase(PHASE_ITEMS);
        cmd_bus.valid <= 1'b0;
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_capacity($urandom_range(12, 3));
        run_random_phase(PHASE_ITEMS);
        cmd_bus.valid <= 1'b0;
        wait_drained();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
